### src/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press detect.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int BUTTONS       = 16;
  localparam int COUNTER_WIDTH = 16;

  localparam int ScanW    = 16;  // shift register word width
  localparam int CmdW     = 2;
  localparam int BtnNumW  = 4;   // width of the button number field
  localparam int TicksW   = 16;  // width of the long_press_ticks register
  localparam int BtnIdxW  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  localparam logic [TicksW-1:0] ResetTicks = 16'd20;

  typedef enum logic [CmdW-1:0] {
    CMD_SCAN       = 2'd0,
    CMD_READ_SHORT = 2'd1,
    CMD_READ_LONG  = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_e;

  // scan position (0 = MSB of the word) to button number, groups of four
  function automatic int pos_to_button(input int pos);
    int btn;
    if (pos < 4) begin
      btn = pos + 4;
    end else if (pos < 8) begin
      btn = 7 - pos;
    end else if (pos < 12) begin
      btn = pos + 4;
    end else begin
      btn = 23 - pos;
    end
    return btn;
  endfunction

endpackage

### src/button_debounce_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Three-sample debouncer for a scanned button word, with short/long press
// flags and read-clear queries.
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------
// in       | input     | in_valid_i / in_stall_o| command_i, raw_word_i,
//          |           |                        | button_number_i
// out      | output    | out_valid_o/out_stall_i| event_seen_o
// cfg      | input     | cfg_we_i               | cfg_wdata_i (long_press_ticks)
//
// A scan tick shifts the new sample into the three-sample history, then the
// debounce and hold-counter update runs one button per cycle through a single
// shared decrement/compare step, during which in_stall_o is high.
// Every item yields one result, queued in a two-entry output buffer, so the
// next item is taken while a result still waits on a stalled output.
// rst_ni clears samples, stable state and flags, and loads the hold counters
// with the reset value of long_press_ticks.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdlp_pkg::CmdW-1:0]         command_i,
  input  logic [bdlp_pkg::ScanW-1:0]        raw_word_i,
  input  logic [bdlp_pkg::BtnNumW-1:0]      button_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              event_seen_o,
  input  logic                              cfg_we_i,
  input  logic [bdlp_pkg::TicksW-1:0]       cfg_wdata_i
);

  localparam int NB  = bdlp_pkg::BUTTONS;
  localparam int CW  = bdlp_pkg::COUNTER_WIDTH;
  localparam int IW  = bdlp_pkg::BtnIdxW;
  localparam logic [IW-1:0] LastBtn = IW'(NB - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e               state_q, state_d;
  logic [IW-1:0]        btn_q, btn_d;
  logic [bdlp_pkg::TicksW-1:0] ticks_q, ticks_d;
  logic [NB-1:0]        newest_q, newest_d;
  logic [NB-1:0]        prev_q, prev_d;
  logic [NB-1:0]        older_q, older_d;
  logic [NB-1:0]        stable_q, stable_d;
  logic [NB-1:0]        short_q, short_d;
  logic [NB-1:0]        long_q, long_d;
  logic [CW-1:0]        hold_q [NB];
  logic [CW-1:0]        hold_d [NB];
  logic [1:0]           cnt_q, cnt_d;
  logic                 res0_q, res0_d;
  logic                 res1_q, res1_d;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [NB-1:0]        pressed;
  logic                 result;
  logic                 btn_in_range;
  logic [IW-1:0]        btn_sel;
  logic [CW-1:0]        reload;
  logic [CW-1:0]        dec;
  logic                 smp_n, smp_p, smp_o, stb;

  assign in_stall_o   = (state_q == ST_SCAN) || (cnt_q == 2'd2);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_valid_o  = (cnt_q != 2'd0);
  assign event_seen_o = res0_q;
  assign out_xfer     = out_valid_o && !out_stall_i;

  assign btn_in_range = (32'(button_number_i) < NB);
  assign btn_sel      = button_number_i[IW-1:0];
  assign reload       = ticks_q[CW-1:0];

  // shared unit: one button's counter step per cycle
  assign dec   = hold_q[btn_q] - CW'(1);
  assign smp_n = newest_q[btn_q];
  assign smp_p = prev_q[btn_q];
  assign smp_o = older_q[btn_q];
  assign stb   = stable_q[btn_q];

  // permute the active-low word to button order
  always_comb begin
    int b;
    b = 0;
    pressed = '0;
    for (int i = 0; i < bdlp_pkg::ScanW; i++) begin
      b = bdlp_pkg::pos_to_button(i);
      if (b < NB) begin
        pressed[IW'(b)] = ~raw_word_i[bdlp_pkg::ScanW-1-i];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    btn_d    = btn_q;
    ticks_d  = ticks_q;
    newest_d = newest_q;
    prev_d   = prev_q;
    older_d  = older_q;
    stable_d = stable_q;
    short_d  = short_q;
    long_d   = long_q;
    hold_d   = hold_q;
    result   = 1'b0;

    if (cfg_we_i) begin
      ticks_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (bdlp_pkg::cmd_e'(command_i))
            bdlp_pkg::CMD_SCAN: begin
              older_d  = prev_q;
              prev_d   = newest_q;
              newest_d = pressed;
              btn_d    = '0;
              state_d  = ST_SCAN;
            end
            bdlp_pkg::CMD_READ_SHORT: begin
              if (btn_in_range && short_q[btn_sel]) begin
                result           = 1'b1;
                short_d[btn_sel] = 1'b0;
              end
            end
            bdlp_pkg::CMD_READ_LONG: begin
              if (btn_in_range && long_q[btn_sel]) begin
                result          = 1'b1;
                long_d[btn_sel] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if ((smp_n == smp_p) && (smp_p == smp_o)) begin
          if (smp_p != stb) begin
            stable_d[btn_q] = smp_p;
            if (smp_p) begin
              hold_d[btn_q]  = reload;
              short_d[btn_q] = 1'b1;
            end
          end else if (dec == '0) begin
            hold_d[btn_q] = reload;
            if (stb) begin
              short_d[btn_q] = 1'b0;
              long_d[btn_q]  = 1'b1;
            end
          end else begin
            hold_d[btn_q] = dec;
          end
        end
        if (btn_q == LastBtn) begin
          state_d = ST_IDLE;
        end else begin
          btn_d = btn_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // two-entry result buffer
  always_comb begin
    cnt_d  = cnt_q;
    res0_d = res0_q;
    res1_d = res1_q;
    if (in_xfer && !out_xfer) begin
      if (cnt_q == 2'd0) begin
        res0_d = result;
      end else begin
        res1_d = result;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      res0_d = res1_q;
      cnt_d  = cnt_q - 2'd1;
    end else if (in_xfer && out_xfer) begin
      // only possible with one entry held
      res0_d = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      btn_q    <= '0;
      ticks_q  <= bdlp_pkg::ResetTicks;
      newest_q <= '0;
      prev_q   <= '0;
      older_q  <= '0;
      stable_q <= '0;
      short_q  <= '0;
      long_q   <= '0;
      for (int k = 0; k < NB; k++) begin
        hold_q[k] <= bdlp_pkg::ResetTicks[CW-1:0];
      end
      cnt_q    <= 2'd0;
    end else begin
      state_q  <= state_d;
      btn_q    <= btn_d;
      ticks_q  <= ticks_d;
      newest_q <= newest_d;
      prev_q   <= prev_d;
      older_q  <= older_d;
      stable_q <= stable_d;
      short_q  <= short_d;
      long_q   <= long_d;
      hold_q   <= hold_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

endmodule

### src/bdlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks for button_debounce_long_press, bound to the top level.
// ----------------------------------------------------------------------------
module bdlp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [bdlp_pkg::CmdW-1:0]     command_i,
  input logic [bdlp_pkg::ScanW-1:0]    raw_word_i,
  input logic [bdlp_pkg::BtnNumW-1:0]  button_number_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          event_seen_o
);

  // a stalled input transfer keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(command_i)
      && $stable(raw_word_i) && $stable(button_number_i))
    else $error("input payload changed while stalled");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_seen_o))
    else $error("result dropped or changed while stalled");

  // a scan tick transfer occupies the block for the per-button sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == bdlp_pkg::CMD_SCAN) |=> in_stall_o)
    else $error("input taken during scan sweep");

  // no result is offered once a reset edge has been seen
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);
